/* hdl/tdfdr_pkg.sv */
// ----------------------------------------------------------------------------
// Target-decoy FDR engine package
// Shared widths, group codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package tdfdr_pkg;

	// Count and fixed-point widths.
	localparam int COUNT_BITS = 20;
	localparam int FRAC_BITS  = 16;
	localparam int DEN_BITS   = COUNT_BITS + 1;
	localparam int REM_BITS   = DEN_BITS + 1;
	localparam int FDR_BITS   = 17;
	localparam int STEP_BITS  = $clog2(FRAC_BITS + 1);

	// Input field widths.
	localparam int SHIFT_BITS = 8;
	localparam int MODS_BITS  = 8;

	// Stream widths.
	localparam int S_TDATA_BITS = 16;
	localparam int S_TUSER_BITS = 2;
	localparam int M_TDATA_BITS = 24;
	localparam int M_TUSER_BITS = 3;

	// Match groups.
	localparam int GROUP_BITS = 2;
	localparam int NUM_GROUPS = 4;
	localparam logic [GROUP_BITS-1:0] GRP_PLAIN       = 2'd0;
	localparam logic [GROUP_BITS-1:0] GRP_VAR_MODS    = 2'd1;
	localparam logic [GROUP_BITS-1:0] GRP_ONE_SHIFT   = 2'd2;
	localparam logic [GROUP_BITS-1:0] GRP_MULTI_SHIFT = 2'd3;

	// Rate of 1.0 in the output format.
	localparam logic [FDR_BITS-1:0] FDR_ONE = FDR_BITS'(1) << FRAC_BITS;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// One rate job: numerator over denominator for a classified match.
	typedef struct packed {
		logic [GROUP_BITS-1:0] group;
		logic                  decoy;
		logic [COUNT_BITS-1:0] num;
		logic [DEN_BITS-1:0]   den;
	} fdr_job_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* hdl/tdfdr_front.sv */
// ----------------------------------------------------------------------------
// Target-decoy FDR front end
// Accepts matches, drops zero e-values, classifies each match into its group,
// updates the saturating target and decoy counts and issues a rate job.
// ----------------------------------------------------------------------------
module tdfdr_front
	import tdfdr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    is_decoy,
	input  logic [SHIFT_BITS-1:0]   mass_shifts,
	input  logic [MODS_BITS-1:0]    variable_mods,
	input  logic                    zero_evalue,
	input  queue_stat_t             qstat,
	output logic                    job_push,
	output fdr_job_t                job
);

	logic [COUNT_BITS-1:0] target_counts_q [NUM_GROUPS];
	logic [COUNT_BITS-1:0] decoy_counts_q  [NUM_GROUPS];
	logic [GROUP_BITS-1:0] group;
	logic [COUNT_BITS-1:0] t_cur;
	logic [COUNT_BITS-1:0] d_cur;
	logic [COUNT_BITS-1:0] t_new;
	logic [COUNT_BITS-1:0] d_new;
	logic                  accept;
	logic                  keep;

	// Items are taken whenever the queue has room.
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign keep     = accept && !zero_evalue;
	assign job_push = keep;

	// Group selection by shift count, then by variable modifications.
	always_comb begin
		if (mass_shifts == '0) begin
			group = (variable_mods == '0) ? GRP_PLAIN : GRP_VAR_MODS;
		end else if (mass_shifts == SHIFT_BITS'(1)) begin
			group = GRP_ONE_SHIFT;
		end else begin
			group = GRP_MULTI_SHIFT;
		end
	end

	// Saturating increments of the selected counts.
	assign t_cur = target_counts_q[group];
	assign d_cur = decoy_counts_q[group];
	assign t_new = (t_cur == '1) ? t_cur : t_cur + COUNT_BITS'(1);
	assign d_new = (d_cur == '1) ? d_cur : d_cur + COUNT_BITS'(1);

	// A decoy is rated d / (t + 1), a target d / t, both after the update.
	always_comb begin
		job.group = group;
		job.decoy = is_decoy;
		if (is_decoy) begin
			job.num = d_new;
			job.den = {1'b0, t_cur} + DEN_BITS'(1);
		end else begin
			job.num = d_cur;
			job.den = {1'b0, t_new};
		end
	end

	// Count storage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				target_counts_q[g] <= '0;
				decoy_counts_q[g]  <= '0;
			end
		end else if (keep) begin
			if (is_decoy) begin
				decoy_counts_q[group] <= d_new;
			end else begin
				target_counts_q[group] <= t_new;
			end
		end
	end

endmodule

/* hdl/tdfdr_queue.sv */
// ----------------------------------------------------------------------------
// Target-decoy FDR job queue
// A short first-in first-out queue of rate jobs between front and back.
// ----------------------------------------------------------------------------
module tdfdr_queue
	import tdfdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  fdr_job_t    push_job,
	input  logic        pop,
	output fdr_job_t    head_job,
	output queue_stat_t qstat
);

	fdr_job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;

	assign qstat.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_job    = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

/* hdl/tdfdr_back.sv */
// ----------------------------------------------------------------------------
// Target-decoy FDR back end
// Restoring divider that turns one rate job into a Q16 rate, one quotient
// bit per cycle, followed by the output register.
// ----------------------------------------------------------------------------
module tdfdr_back
	import tdfdr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  queue_stat_t           qstat,
	input  fdr_job_t              head_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [GROUP_BITS-1:0] out_group,
	output logic [FDR_BITS-1:0]   out_fdr,
	output logic                  out_decoy
);

	logic                  busy_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [DEN_BITS-1:0]   rem_q;
	logic [DEN_BITS-1:0]   den_q;
	logic [FDR_BITS-1:0]   quo_q;
	logic [GROUP_BITS-1:0] group_q;
	logic                  decoy_q;
	logic                  out_valid_q;
	logic [GROUP_BITS-1:0] out_group_q;
	logic [FDR_BITS-1:0]   out_fdr_q;
	logic                  out_decoy_q;
	logic [REM_BITS-1:0]   rem_x2;
	logic                  fits;
	logic                  done;
	logic                  out_free;
	logic                  saturate;

	assign out_free = !out_valid_q || out_ready;
	assign done     = busy_q && (step_q == STEP_BITS'(FRAC_BITS));
	assign pop      = !busy_q && !qstat.empty;
	assign saturate = ({1'b0, head_job.num} >= head_job.den);

	// One restoring step: double the remainder and try the denominator.
	assign rem_x2 = {rem_q, 1'b0};
	assign fits   = (rem_x2 >= {1'b0, den_q});

	// Divider control and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= saturate ? STEP_BITS'(FRAC_BITS) : '0;
		end else if (done) begin
			if (out_free) begin
				busy_q <= 1'b0;
			end
		end else if (busy_q) begin
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q   <= {1'b0, head_job.num};
			den_q   <= head_job.den;
			quo_q   <= saturate ? FDR_ONE : '0;
			group_q <= head_job.group;
			decoy_q <= head_job.decoy;
		end else if (busy_q && !done) begin
			rem_q <= fits ? DEN_BITS'(rem_x2 - {1'b0, den_q}) : rem_x2[DEN_BITS-1:0];
			quo_q <= {quo_q[FDR_BITS-2:0], fits};
		end
	end

	// Output register: a finished rate waits here while the next divide runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_group_q <= group_q;
			out_fdr_q   <= quo_q;
			out_decoy_q <= decoy_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_group = out_group_q;
	assign out_fdr   = out_fdr_q;
	assign out_decoy = out_decoy_q;

endmodule

/* hdl/target_decoy_fdr_engine_unit.sv */
// ----------------------------------------------------------------------------
// Target-decoy FDR engine: Q16 false discovery rate per kept match.
// The bit-serial divider takes one job at a time, skipping its steps at rate 1.0;
// the next job leaves the queue once the last rate is in the output register.
// Reset clears all counts, the job queue and the output register.
// ----------------------------------------------------------------------------
module target_decoy_fdr_engine_unit
	import tdfdr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,  // [7:0] mass_shifts, [15:8] variable_mods
	input  logic [S_TUSER_BITS-1:0] s_tuser,  // [0] is_decoy, [1] zero_evalue
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,  // [16:0] fdr_value, [23:17] zero
	output logic [M_TUSER_BITS-1:0] m_tuser   // [1:0] group_id, [2] was_decoy
);

	fdr_job_t              push_job;
	fdr_job_t              head_job;
	queue_stat_t           qstat;
	logic                  job_push;
	logic                  job_pop;
	logic [GROUP_BITS-1:0] out_group;
	logic [FDR_BITS-1:0]   out_fdr;
	logic                  out_decoy;

	// Front end: classify and count.
	tdfdr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.is_decoy      (s_tuser[0]),
		.mass_shifts   (s_tdata[SHIFT_BITS-1:0]),
		.variable_mods (s_tdata[SHIFT_BITS+MODS_BITS-1:SHIFT_BITS]),
		.zero_evalue   (s_tuser[1]),
		.qstat         (qstat),
		.job_push      (job_push),
		.job           (push_job)
	);

	// Job queue.
	tdfdr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.head_job (head_job),
		.qstat    (qstat)
	);

	// Back end: divide and present the result.
	tdfdr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_job  (head_job),
		.pop       (job_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_group (out_group),
		.out_fdr   (out_fdr),
		.out_decoy (out_decoy)
	);

	// Output packing.
	assign m_tdata = {(M_TDATA_BITS - FDR_BITS)'(0), out_fdr};
	assign m_tuser = {out_decoy, out_group};

`ifndef ASSERT_OFF
	// The rate never exceeds 1.0.
	a_fdr_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[FDR_BITS-1:0] <= FDR_ONE))
		else $error("fdr_value above 1.0");

	// The back end only takes a job that is there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !qstat.empty)
		else $error("job taken from an empty queue");

	// A job is never written into a full queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !qstat.full)
		else $error("job written into a full queue");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Target-decoy FDR engine testbench
// Drives classified spectrum matches into the stream input, predicts the
// group, Q16 rate and decoy echo of every kept match from running per-group
// counts, and compares each output item with the oldest prediction. Both
// sides idle at random in the first two of three phases, and one long output
// stall backs up the whole pipe.
// ----------------------------------------------------------------------------
module tb_top;
	import tdfdr_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RANDOM_KEPT  = 1100;
	localparam int PHASE_ONE    = 440;
	localparam int PHASE_TWO    = 880;
	localparam int STALL_AT     = 950;
	localparam int STALL_CYCLES = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int LIMIT_CYCLES = 400000;

	// One input match as the block sees it.
	typedef struct packed {
		logic                  decoy;
		logic [SHIFT_BITS-1:0] shifts;
		logic [MODS_BITS-1:0]  mods;
		logic                  zero_ev;
	} match_t;

	// One predicted output item.
	typedef struct packed {
		logic [GROUP_BITS-1:0] group;
		logic [FDR_BITS-1:0]   fdr;
		logic                  decoy;
	} rate_item_t;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata  = '0;
	logic [S_TUSER_BITS-1:0] s_tuser  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic [M_TUSER_BITS-1:0] m_tuser;

	match_t     match_queue[$];
	rate_item_t pending_rates[$];
	match_t     next_match;
	rate_item_t seen_rate;
	rate_item_t want_rate;

	// Running counts that mirror the block's state.
	logic [COUNT_BITS-1:0] targets_seen[NUM_GROUPS];
	logic [COUNT_BITS-1:0] decoys_seen[NUM_GROUPS];

	int  items_taken = 0;
	int  error_count = 0;
	int  tx_idle_pct;
	int  rx_idle_pct;
	logic rx_hold    = 1'b0;

	target_decoy_fdr_engine_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, wanted %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Appends one match to the list of items still to be sent.
	task automatic add_match(input match_t m);
		match_queue = {match_queue, m};
	endtask

	// Updates the group counts for an accepted match with a nonzero e-value and queues its rate.
	task automatic predict_rate(input match_t m);
		rate_item_t r;
		logic [63:0] num;
		logic [63:0] den;
		if (m.zero_ev)
			return;
		if (m.shifts == 0)
			r.group = (m.mods == 0) ? GRP_PLAIN : GRP_VAR_MODS;
		else if (m.shifts == 1)
			r.group = GRP_ONE_SHIFT;
		else
			r.group = GRP_MULTI_SHIFT;
		if (m.decoy) begin
			if (decoys_seen[r.group] != '1)
				decoys_seen[r.group]++;
			num = 64'(decoys_seen[r.group]);
			den = 64'(targets_seen[r.group]) + 64'd1;
		end else begin
			if (targets_seen[r.group] != '1)
				targets_seen[r.group]++;
			num = 64'(decoys_seen[r.group]);
			den = 64'(targets_seen[r.group]);
		end
		// A ratio at or above one clamps to exactly 1.0.
		if (den == 0 || num >= den)
			r.fdr = FDR_ONE;
		else
			r.fdr = FDR_BITS'((num << FRAC_BITS) / den);
		r.decoy = m.decoy;
		pending_rates = {pending_rates, r};
	endtask

	// Idle rates by phase: receiver-heavy, then sender-heavy, then none.
	always_comb begin
		if (items_taken < PHASE_ONE) begin
			tx_idle_pct = 32;
			rx_idle_pct = 67;
		end else if (items_taken < PHASE_TWO) begin
			tx_idle_pct = 67;
			rx_idle_pct = 32;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	end

	// Driver: predicts on every accepted item and offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_rate('{decoy: s_tuser[0], shifts: s_tdata[7:0],
					mods: s_tdata[15:8], zero_ev: s_tuser[1]});
				items_taken <= items_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (match_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_match = match_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {next_match.mods, next_match.shifts};
					s_tuser  <= {next_match.zero_ev, next_match.decoy};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted output item and throttles tready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_rate.group = m_tuser[1:0];
				seen_rate.decoy = m_tuser[2];
				seen_rate.fdr   = m_tdata[16:0];
				if (pending_rates.size() == 0) begin
					report_mismatch("unexpected item, group", seen_rate.group, -1);
				end else begin
					want_rate = pending_rates.pop_front();
					if (seen_rate.group != want_rate.group)
						report_mismatch("group_id", seen_rate.group, want_rate.group);
					if (seen_rate.fdr != want_rate.fdr)
						report_mismatch("fdr_value", seen_rate.fdr, want_rate.fdr);
					if (seen_rate.decoy != want_rate.decoy)
						report_mismatch("was_decoy", seen_rate.decoy, want_rate.decoy);
				end
			end
			m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// One long output stall while the sender keeps offering, to fill the pipe.
	initial begin
		while (items_taken < STALL_AT)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Hard limit on the run.
	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("tb_top: FAIL");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		match_t m;
		int kept;
		int pick;
		int decoy_pct;

		for (int g = 0; g < NUM_GROUPS; g++) begin
			targets_seen[g] = '0;
			decoys_seen[g]  = '0;
		end

		// Directed part: first items of each group, ratios below, at and
		// above one, field extremes and dropped zero e-value matches.
		add_match('{1'b0, 8'd0,   8'd0,   1'b0});
		add_match('{1'b1, 8'd0,   8'd0,   1'b0});
		add_match('{1'b1, 8'd0,   8'd0,   1'b0});
		add_match('{1'b0, 8'd0,   8'd0,   1'b0});
		add_match('{1'b0, 8'd0,   8'd0,   1'b0});
		add_match('{1'b1, 8'd0,   8'd1,   1'b0});
		add_match('{1'b0, 8'd0,   8'd255, 1'b0});
		add_match('{1'b0, 8'd0,   8'd128, 1'b0});
		add_match('{1'b0, 8'd1,   8'd0,   1'b0});
		add_match('{1'b1, 8'd1,   8'd255, 1'b0});
		add_match('{1'b0, 8'd2,   8'd0,   1'b0});
		add_match('{1'b1, 8'd255, 8'd255, 1'b0});
		add_match('{1'b0, 8'd128, 8'd1,   1'b0});
		add_match('{1'b1, 8'd127, 8'd0,   1'b0});
		add_match('{1'b0, 8'd255, 8'd255, 1'b1});
		add_match('{1'b1, 8'd0,   8'd0,   1'b1});
		add_match('{1'b1, 8'd1,   8'd170, 1'b1});
		add_match('{1'b0, 8'd85,  8'd85,  1'b0});
		add_match('{1'b0, 8'd170, 8'd170, 1'b0});
		add_match('{1'b1, 8'd0,   8'd0,   1'b0});
		// Decoys after the last target of a group.
		add_match('{1'b1, 8'd1,   8'd0,   1'b0});
		add_match('{1'b1, 8'd1,   8'd0,   1'b0});

		// Random part: the decoy share drifts so rates both clamp and stay low.
		kept = 0;
		decoy_pct = 30;
		while (kept < RANDOM_KEPT) begin
			if (kept % 100 == 0)
				decoy_pct = $urandom_range(60, 10);
			m.decoy   = ($urandom_range(99) < decoy_pct);
			m.zero_ev = ($urandom_range(99) < 8);
			pick = $urandom_range(99);
			if (pick < 40)
				m.shifts = 8'd0;
			else if (pick < 65)
				m.shifts = 8'd1;
			else if (pick < 80)
				m.shifts = 8'd2;
			else
				m.shifts = 8'($urandom_range(255));
			m.mods = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255));
			add_match(m);
			if (!m.zero_ev)
				kept++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every item to go in and every rate to come out.
		while (match_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_rates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
